/* design/ppsd_pkg.sv */
// shared types, codes and default-action table for the per-process signal dispatch block
package ppsd_pkg;

    localparam int MAX_PROCS_DEF = 128;
    localparam int NUM_SIGNALS   = 32;
    localparam int SIG_SLOTS     = NUM_SIGNALS + 1;
    localparam int SIGNO_KILL    = 9;
    localparam int SIGNO_STOP    = 19;

    // command kinds
    localparam logic [1:0] KIND_INSTALL = 2'd0;
    localparam logic [1:0] KIND_MASK    = 2'd1;
    localparam logic [1:0] KIND_SEND    = 2'd2;
    localparam logic [1:0] KIND_DELIVER = 2'd3;

    // mask change modes
    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SET     = 2'd2;
    localparam logic [1:0] HOW_BAD     = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_INVALID = 3'd1;
    localparam logic [2:0] STS_NOPERM  = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_NOPROC  = 3'd4;

    // result actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_PENDED  = 3'd1;
    localparam logic [2:0] ACT_CALL    = 3'd2;
    localparam logic [2:0] ACT_IGNORED = 3'd3;
    localparam logic [2:0] ACT_TERM    = 3'd4;
    localparam logic [2:0] ACT_CORE    = 3'd5;
    localparam logic [2:0] ACT_STOP    = 3'd6;
    localparam logic [2:0] ACT_CONT    = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pid;
        logic [5:0]  signal_number;
        logic [31:0] handler_value;
        logic [1:0]  mask_how;
        logic [32:0] signal_set;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  action;
        logic [5:0]  delivered_signal;
        logic [31:0] handler_out;
        logic        last;
    } out_t;

    // per-process context word: handler-written bits, pending and blocked masks
    typedef struct packed {
        logic [32:0] hvalid;
        logic [32:0] pending;
        logic [32:0] blocked;
    } ctx_t;

    typedef enum logic [2:0] {
        EM_PRE,
        EM_NOTFOUND,
        EM_INVALID,
        EM_OK,
        EM_PENDED,
        EM_HANDLER
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      idx_clr;
        logic      idx_inc;
        logic      pid_rd;
        logic      create;
        logic      ctx_rd;
        logic      ctx_cap;
        logic      exec;
        logic      hw_rd;
        logic      scan_clr;
        logic      scan_inc;
        logic      emit;
        emit_sel_t emit_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       pre_fail;
        logic       idx_at_count;
        logic       pid_match;
        logic       table_full;
        logic       how_bad;
        logic       blocked_hit;
        logic       deliv_zero;
        logic       scan_hit;
        logic       res_last;
        logic       out_free;
    } dp_stat_t;

    // default action of each signal
    function automatic logic [2:0] dflt_action(input logic [5:0] sig);
        logic [2:0] a;
        a = ACT_TERM;
        unique case (sig)
            6'd0, 6'd17, 6'd28:                          a = ACT_IGNORED;
            6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd11:   a = ACT_CORE;
            6'd18:                                       a = ACT_CONT;
            6'd19, 6'd20:                                a = ACT_STOP;
            default:                                     a = ACT_TERM;
        endcase
        return a;
    endfunction

endpackage

/* design/per_process_signal_dispatch.sv */
// top level: per-process signal dispatch, controller plus datapath
// one command at a time; a command looks up the process table and reads the matching
// context, and a miss adds a new context (a miss on a full table returns an error)
// send adds a handler read; deliver scans signals 1..32 one per cycle, pausing at each
// delivered signal for its handler read; results stall while the output is not taken
// synchronous active-low reset empties the process table and the output register
module per_process_signal_dispatch #(
    parameter int MAX_PROCS = ppsd_pkg::MAX_PROCS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ppsd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ppsd_pkg::out_t m_data
);
    import ppsd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    ppsd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    // storage and result formation
    ppsd_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_data(s_data), .cmd(cmd), .stat(stat),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

/* design/ppsd_ram.sv */
// generic single-write, single-read ram with registered read data
module ppsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* design/ppsd_dp.sv */
// datapath: command register, context memories, lookup index, scan and result register
module ppsd_dp #(
    parameter int MAX_PROCS = ppsd_pkg::MAX_PROCS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ppsd_pkg::in_t     s_data,
    input  ppsd_pkg::dp_cmd_t cmd,
    output ppsd_pkg::dp_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output ppsd_pkg::out_t    m_data
);
    import ppsd_pkg::*;

    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int HD  = MAX_PROCS * SIG_SLOTS;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int CTXW = $bits(ctx_t);

    in_t          cmd_reg;
    logic [CW-1:0] idx_reg, count_reg;
    logic [5:0]   sig_reg;
    ctx_t         ctx_reg, ctx_rdata, ctx_next, ctx_wdata;
    logic [32:0]  deliv_reg, deliv, sig_bit, set_eff;
    logic [31:0]  pid_rdata, hw_rdata, hword;
    logic [PW-1:0] entry;
    logic [HAW-1:0] hw_addr;
    logic         sig_ok, ctx_we, hw_we;
    logic         m_valid_reg;
    out_t         m_data_reg, res;

    assign entry   = idx_reg[PW-1:0];
    assign sig_bit = 33'd1 << sig_reg;
    assign sig_ok  = (cmd_reg.signal_number >= 6'd1) && (cmd_reg.signal_number <= 6'(NUM_SIGNALS));
    assign deliv   = ctx_reg.pending & ~ctx_reg.blocked & ~33'd1;
    assign set_eff = cmd_reg.signal_set & ~((33'd1 << SIGNO_KILL) | (33'd1 << SIGNO_STOP));
    // entry times slot count, plus signal
    assign hw_addr = (HAW'(entry) << 5) + HAW'(entry) + HAW'(sig_reg);

    // context memories
    ppsd_ram #(.WIDTH(32), .DEPTH(MAX_PROCS)) u_pid_ram (
        .aclk(aclk), .we(cmd.create), .waddr(entry), .wdata(cmd_reg.pid),
        .re(cmd.pid_rd), .raddr(entry), .rdata(pid_rdata)
    );

    ppsd_ram #(.WIDTH(CTXW), .DEPTH(MAX_PROCS)) u_ctx_ram (
        .aclk(aclk), .we(ctx_we), .waddr(entry), .wdata(ctx_wdata),
        .re(cmd.ctx_rd), .raddr(entry), .rdata(ctx_rdata)
    );

    ppsd_ram #(.WIDTH(32), .DEPTH(HD)) u_hw_ram (
        .aclk(aclk), .we(hw_we), .waddr(hw_addr), .wdata(cmd_reg.handler_value),
        .re(cmd.hw_rd), .raddr(hw_addr), .rdata(hw_rdata)
    );

    // context update for the command being executed
    always_comb begin
        ctx_next = ctx_reg;
        unique case (cmd_reg.kind)
            KIND_INSTALL: ctx_next.hvalid = ctx_reg.hvalid | sig_bit;
            KIND_MASK: begin
                unique case (cmd_reg.mask_how)
                    HOW_BLOCK:   ctx_next.blocked = ctx_reg.blocked | set_eff;
                    HOW_UNBLOCK: ctx_next.blocked = ctx_reg.blocked & ~set_eff;
                    HOW_SET:     ctx_next.blocked = set_eff;
                    default:     ctx_next.blocked = ctx_reg.blocked;
                endcase
            end
            KIND_SEND:    ctx_next.pending = ctx_reg.pending | sig_bit;
            default:      ctx_next.pending = ctx_reg.pending & ~deliv;
        endcase
    end

    assign ctx_we    = cmd.create || cmd.exec;
    assign ctx_wdata = cmd.create ? ctx_t'('0) : ctx_next;
    assign hw_we     = cmd.exec && (cmd_reg.kind == KIND_INSTALL);

    // result formation
    assign hword = (ctx_reg.hvalid[sig_reg]) ? hw_rdata : 32'd0;

    always_comb begin
        res = '0;
        res.last = 1'b1;
        unique case (cmd.emit_sel)
            EM_PRE:      res.status = (cmd_reg.kind == KIND_INSTALL && sig_ok) ? STS_NOPERM
                                                                             : STS_INVALID;
            EM_NOTFOUND: res.status = (cmd_reg.kind == KIND_INSTALL || cmd_reg.kind == KIND_MASK)
                                      ? STS_FULL : STS_NOPROC;
            EM_INVALID:  res.status = STS_INVALID;
            EM_OK:       res.status = STS_OK;
            EM_PENDED: begin
                res.action           = ACT_PENDED;
                res.delivered_signal = sig_reg;
            end
            default: begin
                res.delivered_signal = sig_reg;
                res.last             = stat.res_last;
                if (hword > 32'd1) begin
                    res.action      = ACT_CALL;
                    res.handler_out = hword;
                end else if (hword == 32'd1) begin
                    res.action = ACT_IGNORED;
                end else begin
                    res.action = dflt_action(sig_reg);
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.create) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_data;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.load) begin
            sig_reg <= s_data.signal_number;
        end else if (cmd.scan_clr) begin
            sig_reg <= 6'd1;
        end else if (cmd.scan_inc) begin
            sig_reg <= sig_reg + 6'd1;
        end
        if (cmd.ctx_cap) begin
            ctx_reg <= ctx_rdata;
        end
        if (cmd.scan_clr) begin
            deliv_reg <= deliv;
        end else if (cmd.emit && cmd.emit_sel == EM_HANDLER) begin
            deliv_reg <= deliv_reg & ~sig_bit;
        end
        if (cmd.emit) begin
            m_data_reg <= res;
        end
    end

    // status towards the controller
    always_comb begin
        stat.kind         = cmd_reg.kind;
        stat.pre_fail     = ((cmd_reg.kind == KIND_INSTALL) &&
                             (!sig_ok || cmd_reg.signal_number == 6'(SIGNO_KILL) ||
                              cmd_reg.signal_number == 6'(SIGNO_STOP))) ||
                            ((cmd_reg.kind == KIND_SEND) && !sig_ok);
        stat.idx_at_count = (idx_reg == count_reg);
        stat.pid_match    = (pid_rdata == cmd_reg.pid);
        stat.table_full   = (count_reg == CW'(MAX_PROCS));
        stat.how_bad      = (cmd_reg.mask_how == HOW_BAD);
        stat.blocked_hit  = ctx_reg.blocked[sig_reg];
        stat.deliv_zero   = (deliv == 33'd0);
        stat.scan_hit     = deliv_reg[sig_reg];
        stat.res_last     = (cmd_reg.kind != KIND_DELIVER) || ((deliv_reg & ~sig_bit) == 33'd0);
        stat.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

/* design/ppsd_ctrl.sv */
// controller: sequences lookup, creation, execution and delivery scan
module ppsd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ppsd_pkg::dp_stat_t stat,
    output ppsd_pkg::dp_cmd_t  cmd
);
    import ppsd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_LK_RD, ST_LK_CMP, ST_NF,
        ST_CTX_RD, ST_CTX_CAP, ST_EXEC, ST_SCAN, ST_HREAD
    } state_t;

    state_t state_reg, state_next;

    // next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = EM_OK;
        s_ready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (stat.pre_fail) begin
                    if (stat.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EM_PRE;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_LK_RD;
                end
            end
            ST_LK_RD: begin
                if (stat.idx_at_count) begin
                    state_next = ST_NF;
                end else begin
                    cmd.pid_rd = 1'b1;
                    state_next = ST_LK_CMP;
                end
            end
            ST_LK_CMP: begin
                if (stat.pid_match) begin
                    state_next = ST_CTX_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_LK_RD;
                end
            end
            ST_NF: begin
                if (stat.table_full) begin
                    if (stat.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EM_NOTFOUND;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.create = 1'b1;
                    state_next = ST_CTX_RD;
                end
            end
            ST_CTX_RD: begin
                cmd.ctx_rd = 1'b1;
                state_next = ST_CTX_CAP;
            end
            ST_CTX_CAP: begin
                cmd.ctx_cap = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (stat.kind)
                    KIND_INSTALL: begin
                        if (stat.out_free) begin
                            cmd.exec   = 1'b1;
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_MASK: begin
                        if (stat.out_free) begin
                            cmd.exec     = !stat.how_bad;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = stat.how_bad ? EM_INVALID : EM_OK;
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_SEND: begin
                        if (stat.blocked_hit) begin
                            if (stat.out_free) begin
                                cmd.exec     = 1'b1;
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_PENDED;
                                state_next   = ST_IDLE;
                            end
                        end else begin
                            cmd.hw_rd  = 1'b1;
                            state_next = ST_HREAD;
                        end
                    end
                    default: begin
                        if (stat.deliv_zero) begin
                            if (stat.out_free) begin
                                cmd.emit   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            cmd.exec     = 1'b1;
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (stat.scan_hit) begin
                    cmd.hw_rd  = 1'b1;
                    state_next = ST_HREAD;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            default: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_HANDLER;
                    if (stat.res_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.scan_inc = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* design/ppsd_chk.sv */
// port checker for the per-process signal dispatch block, bound to the top level
module ppsd_chk (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input ppsd_pkg::out_t m_data
);
    import ppsd_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // any action other than none comes with status ok
    a_act_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_NONE |-> m_data.status == STS_OK)
        else $error("action with failing status");

    // handler address only on a call, and then above ignore
    a_handler: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.action == ACT_CALL && m_data.handler_out > 32'd1) ||
                    (m_data.action != ACT_CALL && m_data.handler_out == 32'd0))
        else $error("handler address inconsistent with action");

    // signal number present exactly when an action is taken
    a_sig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.action == ACT_NONE && m_data.delivered_signal == 6'd0) ||
                    (m_data.action != ACT_NONE && m_data.delivered_signal >= 6'd1 &&
                     m_data.delivered_signal <= 6'd32))
        else $error("delivered signal inconsistent with action");

    // no result item right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item valid after reset");
endmodule

bind per_process_signal_dispatch ppsd_chk u_ppsd_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
